### hdl/hcr_pkg.sv
`timescale 1ns / 1ps
package hcr_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int MinDim     = 3;
  localparam int RowW       = 10;
  localparam int ColW       = 10;
  localparam int DimW       = 11;
  localparam int CountW     = 21;
  localparam int SlotW      = 3;
  localparam int AddrW      = SlotW + ColW;
  localparam int RamDepth   = 1 << AddrW;
  localparam int PixW       = 8;
  localparam int KW         = 16;
  localparam int RespW      = 43;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 43;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;

  localparam logic [CfgIdxW-1:0] CfgImageWidth     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKQ16           = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCornerThreshold = 3'd3;

  // One queued job: an optional line-buffer write followed by an optional result.
  typedef struct packed {
    logic             wr;
    logic [PixW-1:0]  pixel;
    logic [AddrW-1:0] waddr;
    logic             emit;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
    logic [DimW-1:0]  w;
    logic [DimW-1:0]  h;
  } job_t;

endpackage

### hdl/hcr_ifs.sv
`timescale 1ns / 1ps
interface hcr_pix_if;
  logic                      valid;
  logic                      ready;
  logic [hcr_pkg::PixW-1:0]  pixel;
  logic                      flush;
  modport source (output valid, pixel, flush, input ready);
  modport sink (input valid, pixel, flush, output ready);
endinterface

interface hcr_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [hcr_pkg::RespW-1:0]  response;
  logic                              is_corner;
  logic [hcr_pkg::RowW-1:0]          row;
  logic [hcr_pkg::ColW-1:0]          col;
  logic                              frame_end;
  modport source (output valid, response, is_corner, row, col, frame_end, input ready);
  modport sink (input valid, response, is_corner, row, col, frame_end, output ready);
endinterface

### hdl/hcr_ram.sv
`timescale 1ns / 1ps
module hcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hdl/hcr_front.sv
`timescale 1ns / 1ps
module hcr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hcr_pkg::DimW-1:0]   image_width,
  input  logic [hcr_pkg::DimW-1:0]   image_height,
  hcr_pix_if.sink                    pixels,
  input  logic                       q_full,
  output logic                       push,
  output hcr_pkg::job_t              job
);
  logic [hcr_pkg::RowW-1:0]   in_row, in_row_next, out_row, out_row_next;
  logic [hcr_pkg::ColW-1:0]   in_col, in_col_next, out_col, out_col_next;
  logic [hcr_pkg::CountW-1:0] in_count, in_count_next, out_pos, out_pos_next;
  logic [hcr_pkg::CountW-1:0] frame_total, frame_total_next;
  logic [hcr_pkg::DimW-1:0]   frame_w, frame_w_next, frame_h, frame_h_next;
  logic [hcr_pkg::DimW:0]     emit_at, emit_at_next;
  logic                       draining, draining_next;
  logic [hcr_pkg::DimW-1:0]   cw, ch;
  logic [2*hcr_pkg::DimW-1:0] area;
  logic [hcr_pkg::CountW-1:0] cnt1;
  logic                       acc, do_emit;

  assign pixels.ready = !q_full;
  assign acc = pixels.valid && pixels.ready;

  always_comb begin
    if (image_width < hcr_pkg::DimW'(hcr_pkg::MinDim)) begin
      cw = hcr_pkg::DimW'(hcr_pkg::MinDim);
    end else if (image_width > hcr_pkg::DimW'(hcr_pkg::MaxWidth)) begin
      cw = hcr_pkg::DimW'(hcr_pkg::MaxWidth);
    end else begin
      cw = image_width;
    end
    if (image_height < hcr_pkg::DimW'(hcr_pkg::MinDim)) begin
      ch = hcr_pkg::DimW'(hcr_pkg::MinDim);
    end else if (image_height > hcr_pkg::DimW'(hcr_pkg::MaxHeight)) begin
      ch = hcr_pkg::DimW'(hcr_pkg::MaxHeight);
    end else begin
      ch = image_height;
    end
    area = {{hcr_pkg::DimW{1'b0}}, cw} * {{hcr_pkg::DimW{1'b0}}, ch};
  end

  always_comb begin
    in_row_next = in_row;
    in_col_next = in_col;
    in_count_next = in_count;
    out_row_next = out_row;
    out_col_next = out_col;
    out_pos_next = out_pos;
    frame_w_next = frame_w;
    frame_h_next = frame_h;
    frame_total_next = frame_total;
    emit_at_next = emit_at;
    draining_next = draining;
    cnt1 = in_count + hcr_pkg::CountW'(1);
    job = '0;
    do_emit = 1'b0;
    if (acc) begin
      if (draining) begin
        do_emit = 1'b1;
      end else if (!pixels.flush) begin
        // The first pixel of a frame latches the geometry.
        if (in_count == '0) begin
          frame_w_next = cw;
          frame_h_next = ch;
          frame_total_next = area[hcr_pkg::CountW-1:0];
          emit_at_next = {cw, 1'b0} + (hcr_pkg::DimW+1)'(3);
          out_row_next = '0;
          out_col_next = '0;
          out_pos_next = '0;
        end
        job.wr = 1'b1;
        job.pixel = pixels.pixel;
        job.waddr = {in_row[hcr_pkg::SlotW-1:0], in_col};
        in_count_next = cnt1;
        if ({1'b0, in_col} + hcr_pkg::DimW'(1) >= frame_w_next) begin
          in_col_next = '0;
          in_row_next = in_row + hcr_pkg::RowW'(1);
        end else begin
          in_col_next = in_col + hcr_pkg::ColW'(1);
        end
        if (cnt1 == frame_total) begin
          draining_next = 1'b1;
        end
        if (cnt1 >= hcr_pkg::CountW'(emit_at)) begin
          do_emit = 1'b1;
        end
      end
    end
    if (do_emit) begin
      job.emit = 1'b1;
      job.row = out_row;
      job.col = out_col;
      job.w = frame_w;
      job.h = frame_h;
      job.last = (out_pos + hcr_pkg::CountW'(1)) == frame_total;
      if (job.last) begin
        in_row_next = '0;
        in_col_next = '0;
        in_count_next = '0;
        out_row_next = '0;
        out_col_next = '0;
        out_pos_next = '0;
        draining_next = 1'b0;
      end else begin
        out_pos_next = out_pos + hcr_pkg::CountW'(1);
        if ({1'b0, out_col} + hcr_pkg::DimW'(1) >= frame_w) begin
          out_col_next = '0;
          out_row_next = out_row + hcr_pkg::RowW'(1);
        end else begin
          out_col_next = out_col + hcr_pkg::ColW'(1);
        end
      end
    end
    push = job.wr || job.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
      in_count <= '0;
      out_row <= '0;
      out_col <= '0;
      out_pos <= '0;
      frame_w <= hcr_pkg::DimW'(hcr_pkg::MinDim);
      frame_h <= hcr_pkg::DimW'(hcr_pkg::MinDim);
      frame_total <= hcr_pkg::CountW'(hcr_pkg::MinDim * hcr_pkg::MinDim);
      emit_at <= (hcr_pkg::DimW+1)'(2 * hcr_pkg::MinDim + 3);
      draining <= 1'b0;
    end else begin
      in_row <= in_row_next;
      in_col <= in_col_next;
      in_count <= in_count_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      out_pos <= out_pos_next;
      frame_w <= frame_w_next;
      frame_h <= frame_h_next;
      frame_total <= frame_total_next;
      emit_at <= emit_at_next;
      draining <= draining_next;
    end
  end
endmodule

### hdl/hcr_queue.sv
`timescale 1ns / 1ps
module hcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hcr_pkg::job_t push_job,
  input  logic          pop,
  output hcr_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  hcr_pkg::job_t              entries [hcr_pkg::QueueDepth];
  logic [hcr_pkg::QPtrW-1:0]  wptr, rptr;
  logic [hcr_pkg::QPtrW:0]    count;

  assign empty = count == '0;
  assign full = count == (hcr_pkg::QPtrW+1)'(hcr_pkg::QueueDepth);
  assign head = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + hcr_pkg::QPtrW'(1);
      end
      if (pop) begin
        rptr <= rptr + hcr_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (hcr_pkg::QPtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (hcr_pkg::QPtrW+1)'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (hcr_pkg::QPtrW+1)'(hcr_pkg::QueueDepth))
    else $error("job queue count out of range");
endmodule

### hdl/hcr_back.sv
`timescale 1ns / 1ps
module hcr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  hcr_pkg::job_t                    head,
  input  logic                             q_empty,
  output logic                             pop,
  input  logic [hcr_pkg::KW-1:0]           k_q16,
  input  logic signed [hcr_pkg::RespW-1:0] corner_threshold,
  hcr_res_if.source                        results
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LOAD   = 11'b00000000010,
    S_LWAIT  = 11'b00000000100,
    S_GCALC  = 11'b00000001000,
    S_ACC    = 11'b00000010000,
    S_ACCEND = 11'b00000100000,
    S_NORM   = 11'b00001000000,
    S_MUL    = 11'b00010000000,
    S_KT     = 11'b00100000000,
    S_KTSUM  = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_t;

  state_t state, state_next;

  hcr_pkg::job_t cur;
  logic [2:0]  ly, lx;
  logic [4:0]  lidx, rd_tag;
  logic        rd_vld;
  logic [hcr_pkg::PixW-1:0] win [25];
  logic [hcr_pkg::PixW-1:0] rdata;
  logic [hcr_pkg::AddrW-1:0] raddr, ram_addr;
  logic signed [11:0] rr, cc;
  logic [hcr_pkg::DimW-1:0] hm1, wm1;
  logic [hcr_pkg::RowW-1:0] rowc;
  logic [hcr_pkg::ColW-1:0] colc;

  logic signed [10:0] gx_sh [9];
  logic signed [10:0] gy_sh [9];
  logic signed [10:0] gx_new [9];
  logic signed [10:0] gy_new [9];
  logic [3:0]  gs;
  logic [1:0]  ga, gb, ws;
  logic signed [21:0] sq_xx, sq_yy, sq_xy;
  logic [21:0] pxx, pyy;
  logic signed [22:0] pxy;
  logic        prod_vld;
  logic [24:0] sxx, syy;
  logic signed [25:0] sxy;
  logic [19:0] nxx, nyy;
  logic signed [20:0] nxy;
  logic [20:0] tr;
  logic [39:0] m1, m2;
  logic signed [41:0] m2_full;
  logic [41:0] tr2;
  logic [36:0] ktlo, kthi;
  logic signed [41:0] det;
  logic [41:0] kt;
  logic [57:0] kt_sum;
  logic signed [44:0] resp_wide;
  logic signed [hcr_pkg::RespW-1:0] resp_sat;
  logic        can_load;

  function automatic logic signed [11:0] ext(input logic [hcr_pkg::PixW-1:0] v);
    ext = $signed({4'b0000, v});
  endfunction

  assign pop = (state == S_IDLE) && !q_empty;
  assign can_load = !results.valid || results.ready;
  assign lidx = {ly[2:0], 2'b00} + {2'b00, ly} + {2'b00, lx};

  // Clamped neighbor coordinates give the replicated border.
  always_comb begin
    hm1 = cur.h - hcr_pkg::DimW'(1);
    wm1 = cur.w - hcr_pkg::DimW'(1);
    rr = $signed({2'b00, cur.row}) + $signed({9'b0, ly}) - 12'sd2;
    cc = $signed({2'b00, cur.col}) + $signed({9'b0, lx}) - 12'sd2;
    if (rr[11]) begin
      rowc = '0;
    end else if (rr[10:0] > hm1) begin
      rowc = hm1[hcr_pkg::RowW-1:0];
    end else begin
      rowc = rr[hcr_pkg::RowW-1:0];
    end
    if (cc[11]) begin
      colc = '0;
    end else if (cc[10:0] > wm1) begin
      colc = wm1[hcr_pkg::ColW-1:0];
    end else begin
      colc = cc[hcr_pkg::ColW-1:0];
    end
    raddr = {rowc[hcr_pkg::SlotW-1:0], colc};
    ram_addr = pop ? head.waddr : raddr;
  end

  hcr_ram #(.Width(hcr_pkg::PixW), .Depth(hcr_pkg::RamDepth)) u_lines (
    .clk   (clk),
    .we    (pop && head.wr),
    .addr  (ram_addr),
    .wdata (head.pixel),
    .rdata (rdata)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        logic signed [11:0] gxw, gyw;
        gxw = ext(win[a*5+b]) + (ext(win[(a+1)*5+b]) <<< 1) + ext(win[(a+2)*5+b])
            - ext(win[a*5+b+2]) - (ext(win[(a+1)*5+b+2]) <<< 1) - ext(win[(a+2)*5+b+2]);
        gyw = ext(win[a*5+b]) + (ext(win[a*5+b+1]) <<< 1) + ext(win[a*5+b+2])
            - ext(win[(a+2)*5+b]) - (ext(win[(a+2)*5+b+1]) <<< 1) - ext(win[(a+2)*5+b+2]);
        gx_new[a*3+b] = gxw[10:0];
        gy_new[a*3+b] = gyw[10:0];
      end
    end
  end

  always_comb begin
    ws = {1'b0, ga == 2'd1} + {1'b0, gb == 2'd1};
    sq_xx = gx_sh[0] * gx_sh[0];
    sq_yy = gy_sh[0] * gy_sh[0];
    sq_xy = gx_sh[0] * gy_sh[0];
    m2_full = nxy * nxy;
    kt_sum = {kthi, 21'b0} + {21'b0, ktlo};
    resp_wide = $signed({{3{det[41]}}, det}) - $signed({3'b000, kt});
    if (resp_wide > 45'sd4398046511103) begin
      resp_sat = {1'b0, {(hcr_pkg::RespW-1){1'b1}}};
    end else if (resp_wide < -45'sd4398046511104) begin
      resp_sat = {1'b1, {(hcr_pkg::RespW-1){1'b0}}};
    end else begin
      resp_sat = resp_wide[hcr_pkg::RespW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop && head.emit) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (ly == 3'd4 && lx == 3'd4) begin
          state_next = S_LWAIT;
        end
      end
      S_LWAIT:  state_next = S_GCALC;
      S_GCALC:  state_next = S_ACC;
      S_ACC: begin
        if (gs == 4'd8) begin
          state_next = S_ACCEND;
        end
      end
      S_ACCEND: state_next = S_NORM;
      S_NORM:   state_next = S_MUL;
      S_MUL:    state_next = S_KT;
      S_KT:     state_next = S_KTSUM;
      S_KTSUM:  state_next = S_FIN;
      S_FIN: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_vld <= 1'b0;
      prod_vld <= 1'b0;
      results.valid <= 1'b0;
      ly <= '0;
      lx <= '0;
      gs <= '0;
      ga <= '0;
      gb <= '0;
    end else begin
      state <= state_next;
      rd_vld <= state == S_LOAD;
      prod_vld <= state == S_ACC;
      if (state == S_FIN && can_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (state == S_LOAD) begin
        if (lx == 3'd4) begin
          lx <= '0;
          ly <= (ly == 3'd4) ? 3'd0 : ly + 3'd1;
        end else begin
          lx <= lx + 3'd1;
        end
      end
      if (state == S_ACC) begin
        gs <= (gs == 4'd8) ? 4'd0 : gs + 4'd1;
        if (gb == 2'd2) begin
          gb <= '0;
          ga <= (ga == 2'd2) ? 2'd0 : ga + 2'd1;
        end else begin
          gb <= gb + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    rd_tag <= lidx;
    if (rd_vld) begin
      win[rd_tag] <= rdata;
    end
    if (state == S_GCALC) begin
      for (int i = 0; i < 9; i++) begin
        gx_sh[i] <= gx_new[i];
        gy_sh[i] <= gy_new[i];
      end
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
    end else begin
      if (state == S_ACC) begin
        for (int i = 0; i < 8; i++) begin
          gx_sh[i] <= gx_sh[i+1];
          gy_sh[i] <= gy_sh[i+1];
        end
        pxx <= {2'b00, sq_xx[19:0]} << ws;
        pyy <= {2'b00, sq_yy[19:0]} << ws;
        pxy <= $signed({sq_xy[21], sq_xy}) <<< ws;
      end
      if (prod_vld) begin
        sxx <= sxx + {3'b000, pxx};
        syy <= syy + {3'b000, pyy};
        sxy <= sxy + {{3{pxy[22]}}, pxy};
      end
    end
    if (state == S_NORM) begin
      nxx <= sxx[23:4];
      nyy <= syy[23:4];
      nxy <= sxy[24:4];
      tr <= {1'b0, sxx[23:4]} + {1'b0, syy[23:4]};
    end
    if (state == S_MUL) begin
      m1 <= nxx * nyy;
      m2 <= m2_full[39:0];
      tr2 <= tr * tr;
    end
    if (state == S_KT) begin
      ktlo <= k_q16 * tr2[20:0];
      kthi <= k_q16 * tr2[41:21];
      det <= $signed({2'b00, m1}) - $signed({2'b00, m2});
    end
    if (state == S_KTSUM) begin
      kt <= kt_sum[57:16];
    end
    if (state == S_FIN && can_load) begin
      results.response <= resp_sat;
      results.is_corner <= resp_sat > corner_threshold;
      results.row <= cur.row;
      results.col <= cur.col;
      results.frame_end <= cur.last;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_load_range: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> (ly <= 3'd4 && lx <= 3'd4))
    else $error("window load counters out of range");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && results.valid && !results.ready) |=> state == S_FIN)
    else $error("result overwritten while receiver stalls");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> !pop)
    else $error("job popped during window computation");
endmodule

### hdl/harris_corner_response_core.sv
`timescale 1ns / 1ps
// Harris corner response over a raster stream of 8-bit gray pixels.
// Channel pixels takes one pixel (or a flush tick) per transaction; channel
// results gives one response with corner flag, row, column and frame end.
// The configuration port writes width, height, k and threshold; the user must
// do so only while idle, since the block itself does not enforce it. The first
// result of a frame appears after 2*width+3 pixels; after the last pixel,
// 2*width+2 flush ticks drain the rest of the frame. A front end tracks
// positions and turns each transaction into a job in a four-entry queue.
// The back end pops a job and writes the line memory, then per result makes
// 25 memory reads for the 5x5 window, 9 steps on one shared gradient-product
// unit, and the determinant and trace multiplies. A pixel that yields no
// result only writes the line memory; the back end takes no new job until
// the result of its current job has been handed to the result register.
// Reset restores the default registers and empties the queue; the line
// memory is not cleared, since every read hits a pixel already received.
// While the receiver stalls, the result register holds, the back end waits
// and the queue fills; pixels then see ready low.
module harris_corner_response_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [hcr_pkg::CfgDataW-1:0]   cfg_data,
  hcr_pix_if.sink                        pixels,
  hcr_res_if.source                      results
);
  logic [hcr_pkg::DimW-1:0]          image_width, image_height;
  logic [hcr_pkg::KW-1:0]            k_q16;
  logic signed [hcr_pkg::RespW-1:0]  corner_threshold;
  hcr_pkg::job_t                     push_job, head;
  logic                              push, pop, q_empty, q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= hcr_pkg::DimW'(640);
      image_height <= hcr_pkg::DimW'(480);
      k_q16 <= hcr_pkg::KW'(2621);
      corner_threshold <= hcr_pkg::RespW'(1638);
    end else if (cfg_we) begin
      case (cfg_index)
        hcr_pkg::CfgImageWidth:      image_width <= cfg_data[hcr_pkg::DimW-1:0];
        hcr_pkg::CfgImageHeight:     image_height <= cfg_data[hcr_pkg::DimW-1:0];
        hcr_pkg::CfgKQ16:            k_q16 <= cfg_data[hcr_pkg::KW-1:0];
        hcr_pkg::CfgCornerThreshold: corner_threshold <= cfg_data[hcr_pkg::RespW-1:0];
        default: ;
      endcase
    end
  end

  hcr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .pixels       (pixels),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  hcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  hcr_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .k_q16            (k_q16),
    .corner_threshold (corner_threshold),
    .results          (results)
  );
endmodule
